@@ sv/tle_pkg.sv @@
package tle_pkg;

  localparam int LINE_LEN_DEF = 64;

  localparam int BYTE_W     = 8;
  localparam int EV_W       = 3;
  localparam int CUR_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = EV_W;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BACKSPACE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELETE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO      = 2'd2;

  localparam logic [BYTE_W-1:0] RST_BACKSPACE = 8'h08;
  localparam logic [BYTE_W-1:0] RST_DELETE    = 8'h7F;

  // Event codes of a result.
  localparam logic [EV_W-1:0] EV_ECHO   = 3'd0;
  localparam logic [EV_W-1:0] EV_RIGHT  = 3'd1;
  localparam logic [EV_W-1:0] EV_LEFT   = 3'd2;
  localparam logic [EV_W-1:0] EV_REDRAW = 3'd3;
  localparam logic [EV_W-1:0] EV_ERASE  = 3'd4;
  localparam logic [EV_W-1:0] EV_CHAR   = 3'd5;
  localparam logic [EV_W-1:0] EV_EMPTY  = 3'd6;

  // Escape recognizer phases.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_ESC     = 2'd1;
  localparam logic [1:0] PH_BRACKET = 2'd2;
  localparam logic [1:0] PH_THREE   = 2'd3;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_THREE = 8'h33;
  localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UP_C  = 8'h43;
  localparam logic [BYTE_W-1:0] CH_UP_D  = 8'h44;
  localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;

  typedef struct packed {
    logic [BYTE_W-1:0] backspace_code;
    logic [BYTE_W-1:0] delete_code;
    logic              echo_enable;
  } cfg_t;

  typedef struct packed {
    logic [EV_W-1:0]   event_res;
    logic [BYTE_W-1:0] char_value;
    logic [CUR_W-1:0]  cursor_at;
    logic              last;
  } res_t;

  function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c + CASE_OFS;
    end
    return r;
  endfunction

endpackage

@@ sv/terminal_line_editor_core.sv @@
// A single event passes from its byte through the emit state to the output register;
// an insert or a removal moves each character with one RAM read and one write.
// A line end sends its characters one at a time, each read from the line RAM and then
// offered for output; a byte that gives no result lets the next byte in on the next cycle,
// and a byte that gives a single event without a shift holds the input until its event is taken.
// Reset clears length, cursor, escape phase, configuration and the output stage;
// the line RAM is not cleared, and no clearing pass is needed.
module terminal_line_editor_core import tle_pkg::*; #(
  parameter int LINE_LEN = LINE_LEN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] char_value, [14:8] cursor_at,
                                                 // rest zero
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [2:0] event_res
  output logic                   m_axis_tlast
);

  localparam int AW = $clog2(LINE_LEN);

  cfg_t              cfg_q;
  res_t              res;
  res_t              out_q;
  logic              out_valid_q;
  logic              res_valid;
  logic              res_ready;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.backspace_code <= RST_BACKSPACE;
      cfg_q.delete_code    <= RST_DELETE;
      cfg_q.echo_enable    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BACKSPACE: cfg_q.backspace_code <= cfg_data_i[BYTE_W-1:0];
        REG_DELETE:    cfg_q.delete_code    <= cfg_data_i[BYTE_W-1:0];
        REG_ECHO:      cfg_q.echo_enable    <= cfg_data_i[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  tle_seq #(
    .LINE_LEN(LINE_LEN)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_byte_i   (s_axis_tdata[BYTE_W-1:0]),
    .in_ready_o  (s_axis_tready),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tle_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(LINE_LEN)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: the sequencer may hand over a new result while the old one drains.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tuser  = out_q.event_res;
  assign m_axis_tdata  = {{(OUT_TDATA_W - BYTE_W - CUR_W){1'b0}},
                          out_q.cursor_at, out_q.char_value};

  a_single_event_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != EV_CHAR) |-> m_axis_tlast)
    else $error("single event without last mark");

  a_line_char_cursor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_CHAR) |-> (m_axis_tdata[14:8] == '0))
    else $error("line character with nonzero cursor");

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[14:8] <= CUR_W'(LINE_LEN)))
    else $error("cursor beyond line length");

  a_no_input_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !s_axis_tready)
    else $error("input taken while a result is pending");

endmodule

@@ sv/tle_ram.sv @@
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/tle_seq.sv @@
module tle_seq import tle_pkg::*; #(
  parameter int LINE_LEN = LINE_LEN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cfg_t                        cfg_i,
  input  logic                        in_valid_i,
  input  logic [BYTE_W-1:0]           in_byte_i,
  output logic                        in_ready_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output res_t                        res_o,
  output logic                        mem_we_o,
  output logic [$clog2(LINE_LEN)-1:0] mem_waddr_o,
  output logic [BYTE_W-1:0]           mem_wdata_o,
  output logic                        mem_re_o,
  output logic [$clog2(LINE_LEN)-1:0] mem_raddr_o,
  input  logic [BYTE_W-1:0]           mem_rdata_i
);

  localparam int AW = $clog2(LINE_LEN);
  localparam int LW = AW + 1;
  localparam logic [LW-1:0] LEN_MAX = LW'(LINE_LEN);
  localparam logic [LW-1:0] ONE     = LW'(1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EMIT = 3'd1;
  localparam logic [2:0] ST_LRD  = 3'd2;
  localparam logic [2:0] ST_LOUT = 3'd3;
  localparam logic [2:0] ST_SRD  = 3'd4;
  localparam logic [2:0] ST_SWR  = 3'd5;
  localparam logic [2:0] ST_INS  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [1:0]        phase_q, phase_d;
  logic [LW-1:0]     len_q, len_d;
  logic [LW-1:0]     cur_q, cur_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     lim_q, lim_d;
  logic              ins_q, ins_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic [EV_W-1:0]   ev_q, ev_d;
  logic [BYTE_W-1:0] ch_q, ch_d;

  logic              accept;
  logic              do_rm;
  logic [LW-1:0]     rm_pos;
  logic [LW-1:0]     idx_ext;
  logic              line_last;
  logic [BYTE_W-1:0] b;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE);
  assign b         = in_byte_i;
  assign idx_ext   = {1'b0, idx_q};
  assign line_last = (idx_q == lim_q);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    len_d   = len_q;
    cur_d   = cur_q;
    idx_d   = idx_q;
    lim_d   = lim_q;
    ins_d   = ins_q;
    byte_d  = byte_q;
    ev_d    = ev_q;
    ch_d    = ch_q;
    do_rm   = 1'b0;
    rm_pos  = cur_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q;

    res_valid_o = 1'b0;
    res_o.event_res  = ev_q;
    res_o.char_value = ch_q;
    res_o.cursor_at  = CUR_W'(cur_q);
    res_o.last       = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ch_d = '0;
          case (phase_q)
            PH_ESC: begin
              phase_d = (b == CH_LBRK) ? PH_BRACKET : PH_IDLE;
            end
            PH_BRACKET: begin
              if (b == CH_THREE) begin
                phase_d = PH_THREE;
              end else begin
                phase_d = PH_IDLE;
                if (b == CH_UP_C && cur_q < len_q) begin
                  cur_d   = cur_q + ONE;
                  ev_d    = EV_RIGHT;
                  state_d = ST_EMIT;
                end else if (b == CH_UP_D && cur_q != '0) begin
                  cur_d   = cur_q - ONE;
                  ev_d    = EV_LEFT;
                  state_d = ST_EMIT;
                end
              end
            end
            PH_THREE: begin
              phase_d = PH_IDLE;
              if (b == CH_TILDE && cur_q != '0 && cur_q < len_q) begin
                do_rm  = 1'b1;
                rm_pos = cur_q;
              end
            end
            default: begin
              if (b == CH_ESC) begin
                phase_d = PH_ESC;
              end else if (b == CH_CR || b == CH_LF || b == CH_NUL) begin
                len_d = '0;
                cur_d = '0;
                if (len_q == '0) begin
                  ev_d    = EV_EMPTY;
                  state_d = ST_EMIT;
                end else begin
                  idx_d   = '0;
                  lim_d   = AW'(len_q - ONE);
                  state_d = ST_LRD;
                end
              end else if (b == cfg_i.backspace_code) begin
                if (len_q != '0 && cur_q != '0) begin
                  cur_d = cur_q - ONE;
                  if (cur_q == len_q) begin
                    len_d   = len_q - ONE;
                    ev_d    = EV_ERASE;
                    state_d = ST_EMIT;
                  end else begin
                    do_rm  = 1'b1;
                    rm_pos = cur_q - ONE;
                  end
                end
              end else if (b == cfg_i.delete_code) begin
                if (cur_q != '0 && cur_q < len_q) begin
                  do_rm  = 1'b1;
                  rm_pos = cur_q;
                end
              end else if (b == CH_TAB) begin
                phase_d = PH_IDLE;
              end else if (len_q < LEN_MAX && cur_q <= len_q) begin
                len_d = len_q + ONE;
                cur_d = cur_q + ONE;
                if (cur_q == len_q) begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = AW'(len_q);
                  mem_wdata_o = b;
                  if (cfg_i.echo_enable) begin
                    ev_d    = EV_ECHO;
                    ch_d    = b;
                    state_d = ST_EMIT;
                  end
                end else begin
                  // Open a gap at the cursor by moving the tail up, last entry first.
                  byte_d  = b;
                  ins_d   = 1'b1;
                  idx_d   = AW'(len_q);
                  ev_d    = EV_REDRAW;
                  state_d = ST_SRD;
                end
              end
            end
          endcase
          if (do_rm) begin
            len_d = len_q - ONE;
            idx_d = AW'(rm_pos);
            ins_d = 1'b0;
            ev_d  = EV_REDRAW;
            state_d = (rm_pos + ONE < len_q) ? ST_SRD : ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_LRD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = idx_q;
        state_d     = ST_LOUT;
      end
      ST_LOUT: begin
        res_valid_o      = 1'b1;
        res_o.event_res  = EV_CHAR;
        res_o.char_value = to_lower(mem_rdata_i);
        res_o.last       = line_last;
        if (res_ready_i) begin
          if (line_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = ST_LRD;
          end
        end
      end
      ST_SRD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = ins_q ? (idx_q - AW'(1)) : (idx_q + AW'(1));
        state_d     = ST_SWR;
      end
      ST_SWR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = mem_rdata_i;
        if (ins_q) begin
          if (idx_ext == cur_q) begin
            state_d = ST_INS;
          end else begin
            idx_d   = idx_q - AW'(1);
            state_d = ST_SRD;
          end
        end else begin
          // len_q already holds the shortened length here.
          if (idx_ext + ONE < len_q) begin
            idx_d   = idx_q + AW'(1);
            state_d = ST_SRD;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_INS: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AW'(cur_q - ONE);
        mem_wdata_o = byte_q;
        state_d     = ST_EMIT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_IDLE;
      len_q   <= '0;
      cur_q   <= '0;
      idx_q   <= '0;
      lim_q   <= '0;
      ins_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      idx_q   <= idx_d;
      lim_q   <= lim_d;
      ins_q   <= ins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    ev_q   <= ev_d;
    ch_q   <= ch_d;
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

import tle_pkg::*;

// Tracks the line the editor should hold and the events it should send back.
class line_editor_scoreboard;
  res_t              pending[$];
  logic [BYTE_W-1:0] text[LINE_LEN_DEF];
  int unsigned       len;
  int unsigned       cur;
  logic [1:0]        phase;
  cfg_t              regs;
  int                errors;
  int                bytes_in;
  int                results_seen;
  int                lines_out;
  int                longest_line;

  function new();
    len          = 0;
    cur          = 0;
    phase        = PH_IDLE;
    regs.backspace_code = RST_BACKSPACE;
    regs.delete_code    = RST_DELETE;
    regs.echo_enable    = 1'b1;
    errors       = 0;
    bytes_in     = 0;
    results_seen = 0;
    lines_out    = 0;
    longest_line = 0;
  endfunction

  function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_BACKSPACE: regs.backspace_code = data;
      REG_DELETE:    regs.delete_code = data;
      REG_ECHO:      regs.echo_enable = data[0];
      default: ;
    endcase
  endfunction

  function void push_event(input logic [EV_W-1:0] ev, input logic [BYTE_W-1:0] ch,
                           input logic fin);
    res_t r;
    r.event_res  = ev;
    r.char_value = ch;
    r.cursor_at  = cur[CUR_W-1:0];
    r.last       = fin;
    pending.push_back(r);
  endfunction

  // Closes the gap at pos by shifting the tail of the line down by one.
  function void drop_char(input int unsigned pos);
    int unsigned i;
    for (i = pos; i + 1 < len; i++) begin
      text[i] = text[i + 1];
    end
    len--;
  endfunction

  function void note_byte(input logic [BYTE_W-1:0] b);
    int unsigned i;
    logic [BYTE_W-1:0] c;
    bytes_in++;
    case (phase)
      PH_ESC: begin
        phase = (b == CH_LBRK) ? PH_BRACKET : PH_IDLE;
        return;
      end
      PH_BRACKET: begin
        if (b == CH_THREE) begin
          phase = PH_THREE;
          return;
        end
        phase = PH_IDLE;
        if (b == CH_UP_C && cur < len) begin
          cur++;
          push_event(EV_RIGHT, '0, 1'b1);
        end else if (b == CH_UP_D && cur > 0) begin
          cur--;
          push_event(EV_LEFT, '0, 1'b1);
        end
        return;
      end
      PH_THREE: begin
        phase = PH_IDLE;
        if (b == CH_TILDE && cur > 0 && cur < len) begin
          drop_char(cur);
          push_event(EV_REDRAW, '0, 1'b1);
        end
        return;
      end
      default: ;
    endcase

    if (b == CH_ESC) begin
      phase = PH_ESC;
    end else if (b == CH_CR || b == CH_LF || b == CH_NUL) begin
      i = len;
      len = 0;
      cur = 0;
      if (i == 0) begin
        push_event(EV_EMPTY, '0, 1'b1);
      end else begin
        lines_out++;
        if (i > longest_line) longest_line = i;
        for (int unsigned k = 0; k < i; k++) begin
          c = text[k];
          if (c >= CH_UP_A && c <= CH_UP_Z) c = c + CASE_OFS;
          push_event(EV_CHAR, c, k + 1 == i);
        end
      end
    end else if (b == regs.backspace_code) begin
      if (len != 0 && cur != 0) begin
        if (cur == len) begin
          len--;
          cur--;
          push_event(EV_ERASE, '0, 1'b1);
        end else begin
          drop_char(cur - 1);
          cur--;
          push_event(EV_REDRAW, '0, 1'b1);
        end
      end
    end else if (b == regs.delete_code) begin
      if (cur > 0 && cur < len) begin
        drop_char(cur);
        push_event(EV_REDRAW, '0, 1'b1);
      end
    end else if (b == CH_TAB) begin
      // Tab completion is not supported; the byte is dropped.
    end else if (len < LINE_LEN_DEF) begin
      if (cur == len) begin
        text[len] = b;
        len++;
        cur++;
        if (regs.echo_enable) push_event(EV_ECHO, b, 1'b1);
      end else begin
        for (i = len; i > cur; i--) begin
          text[i] = text[i - 1];
        end
        text[cur] = b;
        len++;
        cur++;
        push_event(EV_REDRAW, '0, 1'b1);
      end
    end
  endfunction

  function void check_result(input res_t got);
    res_t want;
    results_seen++;
    if (pending.size() == 0) begin
      $error("unexpected result: event_res %0d char_value %0h cursor_at %0d last %0b",
             got.event_res, got.char_value, got.cursor_at, got.last);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.event_res !== want.event_res) begin
      $error("event_res: expected %0d, actual %0d", want.event_res, got.event_res);
      errors++;
    end
    if (got.char_value !== want.char_value) begin
      $error("char_value: expected %0h, actual %0h", want.char_value, got.char_value);
      errors++;
    end
    if (got.cursor_at !== want.cursor_at) begin
      $error("cursor_at: expected %0d, actual %0d", want.cursor_at, got.cursor_at);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, actual %0b", want.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT = 600000;
  // Drain wait after the last result, sized to cover the longest internal shift.
  localparam int DRAIN_CYCLES = 4 * LINE_LEN_DEF + 16;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;

  line_editor_scoreboard sb;
  bit                    quiet;
  int                    cycles;
  int                    settings;

  terminal_line_editor_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 28);
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.event_res  = m_axis_tuser;
      got.char_value = m_axis_tdata[7:0];
      got.cursor_at  = m_axis_tdata[14:8];
      got.last       = m_axis_tlast;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               sb.pending.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Holds the byte until its transaction completes; gaps fall only before tvalid rises.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 28) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b);
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic apply_setting(input logic [BYTE_W-1:0] bs, input logic [BYTE_W-1:0] del,
                               input logic echo);
    wait_drained();
    write_reg(REG_BACKSPACE, bs);
    write_reg(REG_DELETE, del);
    write_reg(REG_ECHO, {7'd0, echo});
    settings++;
  endtask

  task automatic send_escape(input logic [BYTE_W-1:0] final_byte);
    send_byte(CH_ESC);
    send_byte(CH_LBRK);
    send_byte(final_byte);
  endtask

  task automatic run_directed();
    send_byte(CH_CR);
    send_byte(RST_BACKSPACE);
    send_escape(CH_UP_D);
    send_byte(CH_UP_A);
    send_byte(CH_UP_Z);
    send_byte(8'h7A);
    send_byte(8'hFF);
    send_byte(8'h40);
    send_escape(CH_UP_D);
    send_byte(8'h51);
    send_byte(RST_BACKSPACE);
    send_byte(RST_DELETE);
    send_byte(CH_ESC);
    send_byte(CH_LBRK);
    send_byte(CH_THREE);
    send_byte(8'h58);
    send_byte(CH_TAB);
    send_byte(RST_BACKSPACE);
    send_byte(CH_LF);
    send_byte(CH_UP_A);
    send_byte(CH_NUL);
  endtask

  // Mostly well-formed editing keystrokes with random content, plus noise.
  task automatic run_random(input int count);
    int target;
    int pick;
    int burst;
    target = sb.bytes_in + count;
    while (sb.bytes_in < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        send_byte($urandom_range(0, 1) ? BYTE_W'($urandom_range(CH_UP_A, CH_UP_Z))
                                       : BYTE_W'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 42) begin
        send_byte(BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 54) begin
        send_escape($urandom_range(0, 1) ? CH_UP_C : CH_UP_D);
      end else if (pick < 61) begin
        send_escape(CH_THREE);
        send_byte(CH_TILDE);
      end else if (pick < 66) begin
        send_byte(CH_ESC);
        if ($urandom_range(0, 1)) send_byte(CH_LBRK);
        if ($urandom_range(0, 1)) send_byte(CH_THREE);
        send_byte(BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 74) begin
        send_byte(sb.regs.backspace_code);
      end else if (pick < 81) begin
        send_byte(sb.regs.delete_code);
      end else if (pick < 84) begin
        send_byte(CH_TAB);
      end else if (pick < 93) begin
        case ($urandom_range(0, 2))
          0: send_byte(CH_CR);
          1: send_byte(CH_LF);
          default: send_byte(CH_NUL);
        endcase
      end else begin
        // A long run of typing, often enough to fill the line and overflow it.
        burst = $urandom_range(10, LINE_LEN_DEF + 6);
        repeat (burst) send_byte(BYTE_W'($urandom_range(8'h20, 8'h7E)));
      end
    end
    end_burst();
  endtask

  initial begin
    sb            = new();
    quiet         = 1'b0;
    settings      = 1;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_BACKSPACE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    run_random(45);

    apply_setting(8'h00, 8'hFF, 1'b0);
    run_random(45);

    // This phase runs with no stalls on either side.
    apply_setting(8'hFF, 8'h00, 1'b1);
    quiet = 1'b1;
    run_random(45);
    quiet = 1'b0;

    // Backspace and delete share a code, so backspace always wins.
    apply_setting(CH_UP_A, CH_UP_A, 1'b1);
    run_random(45);
    send_byte(CH_CR);
    end_burst();

    wait_drained();
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Sent %0d terminal bytes under %0d register settings, checked %0d results.",
             sb.bytes_in, settings, sb.results_seen);
    $display("Emitted %0d non-empty lines, longest %0d characters.", sb.lines_out,
             sb.longest_line);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
